// File: hdl/asmd_pkg.sv
// Shared types and constants of the accelerometer shock and motion detector.
package asmd_pkg;

  // Filter coefficient format and result width
  localparam int unsigned COEFF_BITS = 16;
  localparam int unsigned MAG_BITS   = 14;
  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  // Configuration register file
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_COEFF     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHOCK_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOTION_THRESHOLD = 2'd2;

  localparam logic [COEFF_BITS-1:0] FILTER_COEFF_RST     = 16'd58982;
  localparam logic [MAG_BITS-1:0]   SHOCK_THRESHOLD_RST  = 14'd641;
  localparam logic [MAG_BITS-1:0]   MOTION_THRESHOLD_RST = 14'd38;

  // Datapath commands issued by the sequencer
  typedef struct packed {
    logic       load;   // capture the input beat, clear the sum
    logic       diff;   // diff = sample - estimate
    logic       acc;    // add the last square into the sum
    logic       mlo;    // multiply low diff bits by the gain
    logic       mhi;    // multiply high diff bits by the gain
    logic       upd;    // write back the new estimate
    logic       res;    // residual magnitude in whole LSB
    logic       sq;     // square the residual
    logic       rinit;  // start the root unit on the finished sum
    logic       rstep;  // one root bit
    logic       emit;   // hand the result to the output register
    logic       ok;     // the current beat carried a good read
    logic [1:0] axis;   // axis being worked on
  } cmd_t;

  // Result of the datapath
  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                shock;
    logic                moving;
  } res_t;

endpackage

// File: hdl/asmd_ctrl.sv
// Sequencer of the detector: walks the three axes, then the square root, on a good read.
module asmd_ctrl #(
  parameter int unsigned SAMPLE_BITS = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            read_ok_i,
  input  logic            out_free_i,
  output logic            in_ready_o,
  output asmd_pkg::cmd_t  cmd_o
);

  localparam int unsigned RW = SAMPLE_BITS + 2;
  localparam int unsigned CW = $clog2(RW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_UPD,
    ST_RES,
    ST_SQ,
    ST_ACC,
    ST_ROOT,
    ST_EMIT
  } state_e;

  state_e         state_q;
  logic [1:0]     axis_q;
  logic [CW-1:0]  cnt_q;
  logic           ok_q;

  // State, axis counter and root step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 2'd0;
      cnt_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ok_q   <= read_ok_i;
            axis_q <= 2'd0;
            state_q <= read_ok_i ? ST_DIFF : ST_EMIT;
          end
        end
        ST_DIFF: state_q <= ST_MLO;
        ST_MLO:  state_q <= ST_MHI;
        ST_MHI:  state_q <= ST_UPD;
        ST_UPD:  state_q <= ST_RES;
        ST_RES:  state_q <= ST_SQ;
        ST_SQ: begin
          if (axis_q == 2'd2) begin
            state_q <= ST_ACC;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= ST_DIFF;
          end
        end
        ST_ACC: begin
          cnt_q   <= CW'(RW - 1);
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    cmd_o.ok    = ok_q;
    cmd_o.load  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.diff  = (state_q == ST_DIFF);
    cmd_o.acc   = ((state_q == ST_DIFF) && (axis_q != 2'd0)) || (state_q == ST_ACC);
    cmd_o.mlo   = (state_q == ST_MLO);
    cmd_o.mhi   = (state_q == ST_MHI);
    cmd_o.upd   = (state_q == ST_UPD);
    cmd_o.res   = (state_q == ST_RES);
    cmd_o.sq    = (state_q == ST_SQ);
    cmd_o.rinit = (state_q == ST_ACC);
    cmd_o.rstep = (state_q == ST_ROOT);
    cmd_o.emit  = (state_q == ST_EMIT) && out_free_i;
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// File: hdl/asmd_dp.sv
// Datapath: gravity estimates, shared multiplier, sum of squares, bit-serial root.
module asmd_dp #(
  parameter int unsigned SAMPLE_BITS = 13,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  asmd_pkg::cmd_t                        cmd_i,
  input  logic [SAMPLE_BITS-1:0]                accel_x_i,
  input  logic [SAMPLE_BITS-1:0]                accel_y_i,
  input  logic [SAMPLE_BITS-1:0]                accel_z_i,
  input  logic [asmd_pkg::COEFF_BITS-1:0]       filter_coeff_i,
  input  logic [asmd_pkg::MAG_BITS-1:0]         shock_thr_i,
  input  logic [asmd_pkg::MAG_BITS-1:0]         motion_thr_i,
  output asmd_pkg::res_t                        res_o
);

  localparam int unsigned CB   = asmd_pkg::COEFF_BITS;
  localparam int unsigned MB   = asmd_pkg::MAG_BITS;
  localparam int unsigned GW   = SAMPLE_BITS + FRAC_BITS;   // estimate width
  localparam int unsigned DW   = GW + 1;                    // difference width
  localparam int unsigned HW   = DW - CB;                   // high part of diff
  localparam int unsigned MW   = (HW > CB + 2) ? HW : CB + 2;
  localparam int unsigned RB   = SAMPLE_BITS + 1;           // residual width
  localparam int unsigned SQW  = 2 * RB;                    // square width
  localparam int unsigned SUMW = 2 * SAMPLE_BITS + 4;       // sum of three squares
  localparam int unsigned RW   = SUMW / 2;                  // root width
  localparam int unsigned EW   = (RW > MB) ? RW : MB;

  logic [SAMPLE_BITS-1:0] samp_q [3];
  logic signed [GW-1:0]   grav_q [3];
  logic signed [DW-1:0]   diff_q;
  logic signed [2*MW-1:0] prod_q;
  logic [CB-1:0]          frac_q;
  logic [RB-1:0]          resid_q;
  logic [SUMW-1:0]        sum_q;
  logic [SUMW-1:0]        rad_q;
  logic [RW+1:0]          rem_q;
  logic [RW-1:0]          root_q;

  // Current axis: sample raised to the estimate's fraction, and its estimate
  logic signed [GW-1:0] s_cur;
  logic signed [GW-1:0] g_cur;
  assign s_cur = {samp_q[cmd_i.axis], {FRAC_BITS{1'b0}}};
  assign g_cur = grav_q[cmd_i.axis];

  // Gain = 1 - alpha, exactly one when alpha is zero
  logic [CB:0] gain;
  assign gain = (CB + 1)'(1 << CB) - {1'b0, filter_coeff_i};

  // Difference and its split around the coefficient's binary point
  logic signed [DW-1:0] diff_d;
  logic [CB-1:0]        diff_lo;
  logic signed [HW-1:0] diff_hi;
  assign diff_d  = DW'(s_cur) - DW'(g_cur);
  assign diff_lo = diff_q[CB-1:0];
  assign diff_hi = diff_q[DW-1:CB];

  // Shared signed multiplier
  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;
  logic signed [2*MW-1:0] prod_d;
  always_comb begin
    if (cmd_i.sq) begin
      mul_a = MW'(resid_q);
      mul_b = MW'(resid_q);
    end else if (cmd_i.mhi) begin
      mul_a = MW'(diff_hi);
      mul_b = MW'(gain);
    end else begin
      mul_a = MW'(diff_lo);
      mul_b = MW'(gain);
    end
  end
  assign prod_d = mul_a * mul_b;

  // New estimate: g + hi*gain + floor(lo*gain / 2^16)
  logic signed [DW:0] upd_sum;
  assign upd_sum = (DW + 1)'(g_cur)
                 + (DW + 1)'(signed'(prod_q[DW-1:0]))
                 + (DW + 1)'({1'b0, frac_q});

  // Residual, truncated toward zero
  logic signed [DW-1:0] resid_d;
  logic [DW-1:0]        resid_abs;
  assign resid_d   = DW'(s_cur) - DW'(g_cur);
  assign resid_abs = resid_d[DW-1] ? DW'(-resid_d) : DW'(resid_d);

  // Running sum of squares
  logic [SUMW-1:0] sum_d;
  assign sum_d = sum_q + SUMW'(prod_q[SQW-1:0]);

  // One restoring square-root step
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;
  assign rem_sh = {rem_q[RW-1:0], rad_q[SUMW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // Gravity estimates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        grav_q[i] <= '0;
      end
    end else if (cmd_i.upd) begin
      grav_q[cmd_i.axis] <= upd_sum[GW-1:0];
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      samp_q[0] <= accel_x_i;
      samp_q[1] <= accel_y_i;
      samp_q[2] <= accel_z_i;
      sum_q     <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= sum_d;
    end
    if (cmd_i.diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.mlo || cmd_i.mhi || cmd_i.sq) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mhi) begin
      frac_q <= prod_q[2*CB-1:CB];
    end
    if (cmd_i.res) begin
      resid_q <= resid_abs[DW-1:FRAC_BITS];
    end
    if (cmd_i.rinit) begin
      rad_q  <= sum_d;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.rstep) begin
      rad_q <= {rad_q[SUMW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
  end

  // Saturate and compare
  logic [EW-1:0] root_ext;
  logic [MB-1:0] mag;
  assign root_ext = EW'(root_q);
  assign mag = (root_ext > EW'(asmd_pkg::MAG_MAX)) ? asmd_pkg::MAG_MAX : root_ext[MB-1:0];

  assign res_o.magnitude = mag;
  assign res_o.shock     = (mag >= shock_thr_i);
  assign res_o.moving    = (mag >= motion_thr_i);

endmodule

// File: hdl/accel_shock_motion_detector.sv
// Top level of the accelerometer shock and motion detector.
// Each input beat is one three-axis sample plus a read-ok flag; every beat yields
// exactly one result beat. A good read runs six steps per axis through one shared
// multiplier for the gravity update and the residual square, one step to finish
// the sum, then the bit-serial square root, one root bit per cycle. A failed read
// leaves the gravity estimates alone and goes straight to the emit state with an
// all-zero result. One beat is worked at a time; the result register lets the
// next sample be taken while the previous result waits downstream. Configuration
// writes are always accepted and must only be issued while the block is idle.
module accel_shock_motion_detector #(
  parameter int unsigned SAMPLE_BITS = 13,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Sample stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [accel_x, accel_y, accel_z] from bit 0 up, zero padded to bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // [read_ok]
  input  logic                                   s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [magnitude] from bit 0 up, zero padded to bytes
  output logic [15:0]                            m_axis_tdata,
  // [shock, moving, valid_res] from bit 0 up
  output logic [2:0]                             m_axis_tuser,
  // Configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [asmd_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [asmd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned MB = asmd_pkg::MAG_BITS;

  asmd_pkg::cmd_t cmd;
  asmd_pkg::res_t res;

  logic [asmd_pkg::COEFF_BITS-1:0] coeff_q;
  logic [MB-1:0]                   shock_thr_q;
  logic [MB-1:0]                   motion_thr_q;

  logic          out_valid_q;
  logic [MB-1:0] out_mag_q;
  logic          out_shock_q;
  logic          out_moving_q;
  logic          out_ok_q;
  logic          out_free;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q      <= asmd_pkg::FILTER_COEFF_RST;
      shock_thr_q  <= asmd_pkg::SHOCK_THRESHOLD_RST;
      motion_thr_q <= asmd_pkg::MOTION_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        asmd_pkg::REG_FILTER_COEFF:     coeff_q      <= cfg_data_i;
        asmd_pkg::REG_SHOCK_THRESHOLD:  shock_thr_q  <= cfg_data_i[MB-1:0];
        asmd_pkg::REG_MOTION_THRESHOLD: motion_thr_q <= cfg_data_i[MB-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  assign out_free = !out_valid_q || m_axis_tready;

  asmd_ctrl #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .read_ok_i  (s_axis_tuser),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // Datapath
  asmd_dp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .accel_x_i      (s_axis_tdata[SB-1:0]),
    .accel_y_i      (s_axis_tdata[2*SB-1:SB]),
    .accel_z_i      (s_axis_tdata[3*SB-1:2*SB]),
    .filter_coeff_i (coeff_q),
    .shock_thr_i    (shock_thr_q),
    .motion_thr_i   (motion_thr_q),
    .res_o          (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      out_mag_q    <= cmd.ok ? res.magnitude : '0;
      out_shock_q  <= cmd.ok && res.shock;
      out_moving_q <= cmd.ok && res.moving;
      out_ok_q     <= cmd.ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_mag_q);
  assign m_axis_tuser  = {out_ok_q, out_moving_q, out_shock_q};

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the accelerometer shock and motion detector.
module testbench;

  localparam int SAMPLE_W = 13;
  localparam int TDATA_W  = ((3*SAMPLE_W+7)/8)*8;
  localparam int SAMPLE_MIN = -4096;
  localparam int SAMPLE_MAX = 4095;
  localparam longint FRAC_ONE = 64'sd65536;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [asmd_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  // One expected result beat
  typedef struct packed {
    logic [asmd_pkg::MAG_BITS-1:0] magnitude;
    logic                          shock;
    logic                          moving;
    logic                          valid_res;
  } detection_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [TDATA_W-1:0]                 s_axis_tdata = '0;
  logic                               s_axis_tuser = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [15:0]                        m_axis_tdata;
  logic [2:0]                         m_axis_tuser;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [asmd_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [asmd_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;

  // Predictor state: gravity estimates and register copies
  longint                        grav_est [3] = '{0, 0, 0};
  logic [15:0]                   coeff_model = asmd_pkg::FILTER_COEFF_RST;
  logic [asmd_pkg::MAG_BITS-1:0] shock_thr_model = asmd_pkg::SHOCK_THRESHOLD_RST;
  logic [asmd_pkg::MAG_BITS-1:0] motion_thr_model = asmd_pkg::MOTION_THRESHOLD_RST;

  detection_t pending_detections [$];
  int mismatches = 0;

  // Traffic shaping knobs shared with the ready generator
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold_req = 0;
  int rx_stall_left = 0;

  accel_shock_motion_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = int'($urandom_range(0, 99));
    if (roll < 65) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic int clamp_sample(input int v);
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  function automatic int any_sample();
    return int'($urandom_range(0, 8191)) + SAMPLE_MIN;
  endfunction

  // Largest r with r*r <= v, built one bit at a time from the top
  function automatic longint floor_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int k = 20; k >= 0; k--) begin
      t = r | (64'sd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Gravity update, residual magnitude and threshold flags for one sample
  function automatic detection_t predict_detection(input logic signed [SAMPLE_W-1:0] ax,
                                                   input logic signed [SAMPLE_W-1:0] ay,
                                                   input logic signed [SAMPLE_W-1:0] az,
                                                   input logic ok);
    detection_t det;
    logic signed [SAMPLE_W-1:0] smp [3];
    logic [asmd_pkg::MAG_BITS-1:0] mag;
    longint gain, s, g, resid, sumsq, root;
    det = '0;
    if (!ok) return det;
    smp[0] = ax;
    smp[1] = ay;
    smp[2] = az;
    gain = FRAC_ONE - longint'(coeff_model);
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      s = longint'(smp[i]) * FRAC_ONE;
      // arithmetic shift floors toward minus infinity
      g = grav_est[i] + (((s - grav_est[i]) * gain) >>> 16);
      grav_est[i] = g;
      resid = s - g;
      if (resid < 0) resid = -resid;
      resid = resid >>> 16;
      sumsq += resid * resid;
    end
    root = floor_root(sumsq);
    if (root > longint'(asmd_pkg::MAG_MAX)) root = longint'(asmd_pkg::MAG_MAX);
    mag = root[asmd_pkg::MAG_BITS-1:0];
    det.magnitude = mag;
    det.shock     = (mag >= shock_thr_model);
    det.moving    = (mag >= motion_thr_model);
    det.valid_res = 1'b1;
    return det;
  endfunction

  // Result ready: random stalls, steady stretches, and long hold-offs on request
  always @(posedge clk_i) begin : rx_ready_gen
    int gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = 0;
    end else if (rx_hold_req != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left = rx_hold_req - 1;
      rx_hold_req = 0;
    end else if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      gap = pick_gap();
      if (gap == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_stall_left = gap - 1;
      end
    end
  end

  // Compare every result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    detection_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_detections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat at %0t: tdata=%0d tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_detections.pop_front();
        if (m_axis_tdata != {2'b00, want.magnitude} ||
            m_axis_tuser != {want.valid_res, want.moving, want.shock}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected mag=%0d tuser=%b, got mag=%0d tuser=%b",
                     $time, want.magnitude, {want.valid_res, want.moving, want.shock},
                     m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  // Offer one sample beat and record its prediction once accepted
  task automatic send_sample(input int ax, input int ay, input int az, input bit ok);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, az[SAMPLE_W-1:0], ay[SAMPLE_W-1:0], ax[SAMPLE_W-1:0]};
    s_axis_tuser  <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_detections.push_back(
      predict_detection(ax[SAMPLE_W-1:0], ay[SAMPLE_W-1:0], az[SAMPLE_W-1:0], ok));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_detections.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [asmd_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      asmd_pkg::REG_FILTER_COEFF:     coeff_model = val;
      asmd_pkg::REG_SHOCK_THRESHOLD:  shock_thr_model = val[asmd_pkg::MAG_BITS-1:0];
      asmd_pkg::REG_MOTION_THRESHOLD: motion_thr_model = val[asmd_pkg::MAG_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reset register values, device at rest then a hard swing
  task automatic test_reset_config();
    send_sample(0, 0, 256, 1'b1);
    send_sample(0, 0, 256, 1'b1);
    send_sample(10, -10, 256, 1'b1);
    send_sample(0, 0, SAMPLE_MIN, 1'b1);
  endtask

  task automatic test_sample_extremes();
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_sample(0, 0, 0, 1'b1);
    send_sample(-1, 1, -1, 1'b1);
  endtask

  // Failed reads must return zeros and leave the estimates alone
  task automatic test_failed_read();
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 1234, 1'b0);
    send_sample(-1, -1, -1, 1'b0);
    send_sample(0, 0, 256, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, 0, 1'b0);
  endtask

  // Zero coefficient tracks the sample exactly; full coefficient barely moves
  task automatic test_coeff_extremes();
    wait_drain();
    write_reg(asmd_pkg::REG_FILTER_COEFF, 16'd0);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 100, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, -100, 1'b1);
    send_sample(0, 0, 0, 1'b1);
    wait_drain();
    write_reg(asmd_pkg::REG_FILTER_COEFF, 16'hFFFF);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
  endtask

  // Zero thresholds flag every good read; top thresholds flag nothing reachable
  task automatic test_threshold_extremes();
    wait_drain();
    write_reg(asmd_pkg::REG_SHOCK_THRESHOLD, 16'd0);
    write_reg(asmd_pkg::REG_MOTION_THRESHOLD, 16'd0);
    write_reg(REG_SPARE, 16'($urandom));
    send_sample(0, 0, 0, 1'b1);
    send_sample(100, 0, 0, 1'b0);
    send_sample(300, 300, 300, 1'b1);
    wait_drain();
    write_reg(asmd_pkg::REG_SHOCK_THRESHOLD, 16'hFFFF);
    write_reg(asmd_pkg::REG_MOTION_THRESHOLD, 16'hFFFF);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
  endtask

  // Long receiver hold-off while the sender keeps pushing beats
  task automatic test_backpressure();
    wait_drain();
    write_reg(asmd_pkg::REG_FILTER_COEFF, asmd_pkg::FILTER_COEFF_RST);
    write_reg(asmd_pkg::REG_SHOCK_THRESHOLD, 16'(asmd_pkg::SHOCK_THRESHOLD_RST));
    write_reg(asmd_pkg::REG_MOTION_THRESHOLD, 16'(asmd_pkg::MOTION_THRESHOLD_RST));
    rx_hold_req = 300;
    tx_steady = 1'b1;
    for (int n = 0; n < 12; n++)
      send_sample(any_sample(), any_sample(), any_sample(), n != 5);
    wait_drain();
    tx_steady = 1'b0;
  endtask

  // Resting orientations with sensor noise, shock spikes, and some junk reads
  task automatic run_motion_stream(input int count);
    int base [3];
    int v [3];
    int run_left;
    int roll;
    int spike;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        for (int k = 0; k < 3; k++) base[k] = int'($urandom_range(0, 120)) - 60;
        base[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? 256 : -256;
        run_left = int'($urandom_range(10, 60));
      end
      run_left--;
      roll = int'($urandom_range(0, 99));
      if (roll < 14) begin
        send_sample(any_sample(), any_sample(), any_sample(), roll >= 6);
      end else begin
        for (int k = 0; k < 3; k++) v[k] = base[k] + int'($urandom_range(0, 40)) - 20;
        if (roll < 24) begin
          spike = int'($urandom_range(100, 4000));
          if ($urandom_range(0, 1) != 0) spike = -spike;
          v[$urandom_range(0, 2)] += spike;
        end
        send_sample(clamp_sample(v[0]), clamp_sample(v[1]), clamp_sample(v[2]), 1'b1);
      end
    end
  endtask

  // Random traffic across a series of register settings
  task automatic test_random_settings();
    logic [15:0] coeff_val;
    logic [15:0] shock_val;
    logic [15:0] motion_val;
    for (int p = 0; p < 8; p++) begin
      wait_drain();
      case (p % 4)
        0: coeff_val = 16'($urandom);
        1: coeff_val = 16'($urandom_range(50000, 65535));
        2: coeff_val = (p == 2) ? 16'hFFFF : 16'd1;
        default: coeff_val = asmd_pkg::FILTER_COEFF_RST;
      endcase
      if (p == 5) begin
        shock_val  = 16'($urandom);
        motion_val = 16'($urandom);
      end else begin
        shock_val  = 16'($urandom_range(0, 900));
        motion_val = 16'($urandom_range(0, 200));
        shock_val[15:14]  = 2'($urandom_range(0, 3));
        motion_val[15:14] = 2'($urandom_range(0, 3));
      end
      write_reg(asmd_pkg::REG_FILTER_COEFF, coeff_val);
      write_reg(asmd_pkg::REG_SHOCK_THRESHOLD, shock_val);
      write_reg(asmd_pkg::REG_MOTION_THRESHOLD, motion_val);
      tx_steady = (p == 2 || p == 6);
      rx_steady = (p == 3 || p == 6);
      run_motion_stream(225);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_sample_extremes();
    test_failed_read();
    test_coeff_extremes();
    test_threshold_extremes();
    test_backpressure();
    test_random_settings();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (pending_detections.size() != 0) begin
      mismatches++;
      $display("%0d result beats never arrived", pending_detections.size());
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
